// ===== sv/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_CODE  = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	// One decoded result
	typedef struct packed {
		logic [15:0] code_point;
		kind_t       kind;
	} result_t;

	// Decoder step outcome handed to the output register
	typedef struct packed {
		logic    has_result;
		result_t res;
	} step_out_t;

	// Continuation bytes still expected
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	// Byte class prefixes
	localparam logic [1:0] CONT_TAG  = 2'b10;   // 10xxxxxx
	localparam logic [2:0] LEAD2_TAG = 3'b110;  // 110xxxxx
	localparam logic [3:0] LEAD3_TAG = 4'b1110; // 1110xxxx

endpackage

// ===== sv/utf8d_byte_if.sv =====
// ----------------------------------------------------------------------------
// utf8d_byte_if
// Byte stream channel: one UTF-8 byte per transaction.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== sv/utf8d_cp_if.sv =====
// ----------------------------------------------------------------------------
// utf8d_cp_if
// Result channel: one code point, error or end marker per transaction.
// ----------------------------------------------------------------------------
interface utf8d_cp_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_point;
	logic [1:0]  kind;

	modport source (output valid, output code_point, output kind, input ready);
	modport sink   (input valid, input code_point, input kind, output ready);
endinterface

// ===== sv/utf8d_core.sv =====
// ----------------------------------------------------------------------------
// utf8d_core
// Sequence state and single-byte decode step.
// ----------------------------------------------------------------------------
module utf8d_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic [7:0]           byte_s1,
	output utf8d_pkg::step_out_t step
);

	logic [1:0]  pending_q;
	logic [15:0] partial_q;
	logic        discard_q;

	logic [1:0]  pending_d;
	logic [15:0] partial_d;
	logic        discard_d;
	logic [15:0] shifted;

	assign shifted = {partial_q[9:0], byte_s1[5:0]};

	always_comb begin
		step.has_result     = 1'b0;
		step.res.code_point = '0;
		step.res.kind       = utf8d_pkg::KIND_CODE;
		pending_d           = pending_q;
		partial_d           = partial_q;
		discard_d           = discard_q;

		if (discard_q) begin
			// dropping until end of string
			if (byte_s1 == 8'h00) begin
				step.has_result = 1'b1;
				step.res.kind   = utf8d_pkg::KIND_END;
				discard_d       = 1'b0;
				pending_d       = utf8d_pkg::PEND_NONE;
				partial_d       = '0;
			end
		end else if (pending_q != utf8d_pkg::PEND_NONE) begin
			if (byte_s1 == 8'h00) begin
				// string ended mid-sequence: error, no discard
				step.has_result = 1'b1;
				step.res.kind   = utf8d_pkg::KIND_ERROR;
				pending_d       = utf8d_pkg::PEND_NONE;
				partial_d       = '0;
			end else if (byte_s1[7:6] != utf8d_pkg::CONT_TAG) begin
				step.has_result = 1'b1;
				step.res.kind   = utf8d_pkg::KIND_ERROR;
				pending_d       = utf8d_pkg::PEND_NONE;
				partial_d       = '0;
				discard_d       = 1'b1;
			end else begin
				pending_d = pending_q - 2'd1;
				if (pending_q == utf8d_pkg::PEND_ONE) begin
					step.has_result     = 1'b1;
					step.res.code_point = shifted;
					partial_d           = '0;
				end else begin
					partial_d = shifted;
				end
			end
		end else begin
			if (byte_s1 == 8'h00) begin
				step.has_result = 1'b1;
				step.res.kind   = utf8d_pkg::KIND_END;
			end else if (!byte_s1[7]) begin
				step.has_result     = 1'b1;
				step.res.code_point = {8'h00, byte_s1};
			end else if (byte_s1[7:5] == utf8d_pkg::LEAD2_TAG) begin
				partial_d = {11'd0, byte_s1[4:0]};
				pending_d = utf8d_pkg::PEND_ONE;
			end else if (byte_s1[7:4] == utf8d_pkg::LEAD3_TAG) begin
				partial_d = {12'd0, byte_s1[3:0]};
				pending_d = utf8d_pkg::PEND_TWO;
			end else begin
				// stray continuation or four-byte/invalid lead
				step.has_result = 1'b1;
				step.res.kind   = utf8d_pkg::KIND_ERROR;
				partial_d       = '0;
				discard_d       = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= utf8d_pkg::PEND_NONE;
			partial_q <= '0;
			discard_q <= 1'b0;
		end else if (step_en) begin
			pending_q <= pending_d;
			partial_q <= partial_d;
			discard_q <= discard_d;
		end
	end

endmodule

// ===== sv/utf8d_out_reg.sv =====
// ----------------------------------------------------------------------------
// utf8d_out_reg
// Result register driving the code point channel.
// ----------------------------------------------------------------------------
module utf8d_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  utf8d_pkg::result_t res,
	output logic               free,
	utf8d_cp_if.source         points
);

	logic               valid_q;
	utf8d_pkg::result_t res_q;

	assign free = !valid_q || points.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (points.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign points.valid      = valid_q;
	assign points.code_point = res_q.code_point;
	assign points.kind       = res_q.kind;

endmodule

// ===== sv/utf8_to_code_point_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder
// UTF-8 byte stream to 16-bit code point decoder (1-, 2- and 3-byte forms).
// ----------------------------------------------------------------------------
// Path: a result passes through the byte register, then the result register,
//   and is further delayed by any result channel stall.
// Throughput: 1 byte per cycle while the result channel does not stall; the
//   decode step is combinational between the byte register and result register.
// Reset: arst_n clears the sequence state, discard flag and both valid bits.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder (
	input  logic       clk,
	input  logic       arst_n,
	utf8d_byte_if.sink text,
	utf8d_cp_if.source points
);

	// Byte stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	utf8d_pkg::step_out_t step;
	logic                 out_free;
	logic                 advance;
	logic                 load;

	// The staged byte moves on when the result register can take its
	// result, or when it produces none (continuation, lead, dropped byte).
	assign advance    = valid_s1 && (out_free || !step.has_result);
	assign load       = advance && step.has_result;
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.in_byte;
		end
	end

	// Decode step with sequence state; state commits only when the byte leaves
	utf8d_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.byte_s1 (byte_s1),
		.step    (step)
	);

	// Result register decouples the consumer from the decode step
	utf8d_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.res    (step.res),
		.free   (out_free),
		.points (points)
	);

	// A result is never loaded over one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("result register overwritten");

	// A zero byte always ends the string with some result
	a_zero_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && byte_s1 == 8'h00) |-> step.has_result)
		else $error("zero byte produced no transaction");

	// Error and end results carry a zero code point
	a_nondata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(points.valid && points.kind != utf8d_pkg::KIND_CODE) |-> points.code_point == 16'h0000)
		else $error("non-data result with nonzero code point");

	// A loaded result is presented in the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> points.valid)
		else $error("loaded result not presented");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the UTF-8 to code point decoder. A directed run covers the
// field extremes, every sequence length and the malformed-input cases,
// followed by random UTF-8 text mixed with broken sequences and noise. A
// scoreboard predicts each result from the accepted bytes and checks the
// decoded stream transaction by transaction, under random idling on both
// channels and long stalls of the result channel.
// ----------------------------------------------------------------------------
module tb;

	// Cycles with no transaction on either channel before the run is aborted
	localparam int STALL_LIMIT = 4000;
	// Length of the forced result-channel stall
	localparam int HOLD_CYCLES = 64;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks the decoder state from accepted bytes and keeps the
	// results that are still owed, oldest first.
	// ------------------------------------------------------------------------
	class code_point_scoreboard;
		logic [1:0]         conts_left;   // continuation bytes still owed
		logic [15:0]        gathered;     // bits of the open sequence
		bit                 dropping;     // skipping bytes until the next zero
		utf8d_pkg::result_t expected_points[$];
		int                 mismatches;

		function new();
			conts_left = utf8d_pkg::PEND_NONE;
			gathered   = '0;
			dropping   = 1'b0;
			mismatches = 0;
		endfunction

		// One accepted byte: advance the state, queue a result if one is due
		function void note_byte(logic [7:0] b);
			utf8d_pkg::result_t r;
			bit                 due;
			due          = 1'b0;
			r.code_point = '0;
			r.kind       = utf8d_pkg::KIND_CODE;
			if (dropping) begin
				if (b == 8'h00) begin
					dropping   = 1'b0;
					conts_left = utf8d_pkg::PEND_NONE;
					gathered   = '0;
					r.kind     = utf8d_pkg::KIND_END;
					due        = 1'b1;
				end
			end else if (conts_left != utf8d_pkg::PEND_NONE) begin
				if (b == 8'h00 || b[7:6] != utf8d_pkg::CONT_TAG) begin
					// zero ends the string, anything else starts a drop
					dropping   = (b != 8'h00);
					conts_left = utf8d_pkg::PEND_NONE;
					gathered   = '0;
					r.kind     = utf8d_pkg::KIND_ERROR;
					due        = 1'b1;
				end else begin
					gathered   = {gathered[9:0], b[5:0]};
					conts_left = conts_left - 2'd1;
					if (conts_left == utf8d_pkg::PEND_NONE) begin
						r.code_point = gathered;
						gathered     = '0;
						due          = 1'b1;
					end
				end
			end else if (b == 8'h00) begin
				r.kind = utf8d_pkg::KIND_END;
				due    = 1'b1;
			end else if (!b[7]) begin
				r.code_point = {8'h00, b};
				due          = 1'b1;
			end else if (b[7:5] == utf8d_pkg::LEAD2_TAG) begin
				gathered   = {11'd0, b[4:0]};
				conts_left = utf8d_pkg::PEND_ONE;
			end else if (b[7:4] == utf8d_pkg::LEAD3_TAG) begin
				gathered   = {12'd0, b[3:0]};
				conts_left = utf8d_pkg::PEND_TWO;
			end else begin
				// stray continuation or four-byte / invalid lead
				dropping = 1'b1;
				r.kind   = utf8d_pkg::KIND_ERROR;
				due      = 1'b1;
			end
			if (due)
				expected_points.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		// One accepted result, compared with the oldest one owed
		task check_point(logic [15:0] cp, logic [1:0] k);
			utf8d_pkg::result_t r;
			if (expected_points.size() == 0) begin
				report($sformatf("unexpected result cp=%h kind=%0d", cp, k));
			end else begin
				r = expected_points.pop_front();
				if (k !== r.kind)
					report($sformatf("kind %0d, expected %0d", k, r.kind));
				if (cp !== r.code_point)
					report($sformatf("code point %h, expected %h", cp, r.code_point));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	utf8d_byte_if text_if ();
	utf8d_cp_if   points_if ();

	utf8_to_code_point_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.points (points_if)
	);

	code_point_scoreboard sb = new();

	int send_idle_pct;     // percent of cycles the byte sender idles
	int recv_idle_pct;     // percent of cycles the result receiver stalls
	bit hold_points;       // request a long stall of the result channel
	int bytes_sent;
	int quiet_cycles;

	// Clock and a single reset pulse at the start
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Observe both channels at the edge; pre-edge values are seen here since
	// every driver on either side updates through nonblocking assignments.
	always @(posedge clk) begin
		if (text_if.valid && text_if.ready)
			sb.note_byte(text_if.in_byte);
		if (points_if.valid && points_if.ready)
			sb.check_point(points_if.code_point, points_if.kind);
	end

	// Watchdog: abort when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (text_if.valid && text_if.ready) ||
				(points_if.valid && points_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result receiver: random back-pressure, or a long hold when requested.
	// The hold is counted here so the sender keeps offering bytes meanwhile.
	initial begin
		points_if.ready <= 1'b0;
		forever begin
			if (hold_points) begin
				points_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_points = 1'b0;
			end else begin
				points_if.ready <= ($urandom_range(99) >= recv_idle_pct);
				@(posedge clk);
			end
		end
	end

	// Offer one byte, idling at random first; returns once it is accepted
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			text_if.valid <= 1'b0;
			@(posedge clk);
		end
		text_if.valid   <= 1'b1;
		text_if.in_byte <= b;
		@(posedge clk);
		while (!text_if.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Wait until every owed result has come back; the first edge lets the
	// monitor note the last accepted byte
	task automatic wait_drained();
		@(posedge clk);
		while (sb.expected_points.size() != 0)
			@(posedge clk);
	endtask

	// Lead byte of a multi-byte form, plus one continuation for some
	// three-byte forms, so a sequence is left open
	task automatic send_open_sequence();
		if ($urandom_range(1)) begin
			send_byte({utf8d_pkg::LEAD2_TAG, 5'($urandom)});
		end else begin
			send_byte({utf8d_pkg::LEAD3_TAG, 4'($urandom)});
			if ($urandom_range(1))
				send_byte({utf8d_pkg::CONT_TAG, 6'($urandom)});
		end
	endtask

	// Bytes that follow an error; most runs close the string with a zero
	task automatic send_junk_then_end();
		int n;
		n = $urandom_range(3);
		repeat (n)
			send_byte(8'($urandom));
		if ($urandom_range(9) < 8)
			send_byte(8'h00);
	endtask

	// Mostly well-formed text with random content, the rest broken forms
	task automatic send_random_text(input int target);
		int         first;
		int         pick;
		logic [7:0] b;
		first = bytes_sent;
		while (bytes_sent - first < target) begin
			pick = $urandom_range(99);
			if (pick < 28) begin
				send_byte(8'($urandom_range(8'h7F, 8'h01)));
			end else if (pick < 48) begin
				send_byte({utf8d_pkg::LEAD2_TAG, 5'($urandom)});
				send_byte({utf8d_pkg::CONT_TAG, 6'($urandom)});
			end else if (pick < 68) begin
				send_byte({utf8d_pkg::LEAD3_TAG, 4'($urandom)});
				send_byte({utf8d_pkg::CONT_TAG, 6'($urandom)});
				send_byte({utf8d_pkg::CONT_TAG, 6'($urandom)});
			end else if (pick < 76) begin
				send_byte(8'h00);
			end else if (pick < 82) begin
				// bad continuation: nonzero byte outside 10xxxxxx
				send_open_sequence();
				do
					b = 8'($urandom);
				while (b == 8'h00 || b[7:6] == utf8d_pkg::CONT_TAG);
				send_byte(b);
				send_junk_then_end();
			end else if (pick < 86) begin
				// zero where a continuation is owed
				send_open_sequence();
				send_byte(8'h00);
			end else if (pick < 90) begin
				send_byte({utf8d_pkg::CONT_TAG, 6'($urandom)});
				send_junk_then_end();
			end else if (pick < 95) begin
				// four-byte lead or 11111xxx
				send_byte({4'b1111, 4'($urandom)});
				send_junk_then_end();
			end else begin
				send_byte(8'($urandom));
			end
		end
	endtask

	// Stimulus
	initial begin
		logic [7:0] directed[$];
		text_if.valid   <= 1'b0;
		text_if.in_byte <= 8'h00;
		hold_points      = 1'b0;
		bytes_sent       = 0;
		send_idle_pct    = 13;
		recv_idle_pct    = 53;

		@(posedge clk);
		while (!arst_n)
			@(posedge clk);

		// Directed: end marker, ASCII extremes, two- and three-byte extremes,
		// bad continuation then a dropped byte, zero inside a sequence,
		// stray continuation, four-byte lead with a dropped 0xFF.
		directed = '{8'h00, 8'h7F, 8'h01,
			8'hC2, 8'h80, 8'hDF, 8'hBF,
			8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
			8'hC3, 8'h41, 8'h55, 8'h00,
			8'hE1, 8'h80, 8'h00,
			8'h80, 8'h00,
			8'hF0, 8'hFF, 8'h00};
		foreach (directed[i])
			send_byte(directed[i]);

		send_random_text(450);

		// Sender pauses until the decoder has handed back everything
		text_if.valid <= 1'b0;
		wait_drained();

		send_idle_pct = 53;
		recv_idle_pct = 13;
		send_random_text(450);

		// Full rate on both sides, with long result stalls so the decoder
		// fills up and pushes back on the byte stream
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_points   = 1'b1;
		send_random_text(200);
		hold_points   = 1'b1;
		send_random_text(300);

		text_if.valid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);

		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
